// ===== rtl/midi_track_event_parser_unit_macros.svh =====
// Assertion macros for the RTL file that checks its own behavior.
// Define NO_ASSERTIONS to compile every check away.
`ifndef MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MTEP_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("check failed");

// The consequent must hold in the cycle after the antecedent.
`define MTEP_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("check failed");

`else

`define MTEP_ASSERT_IMPL(name, ante, cons)
`define MTEP_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// ===== rtl/mtep_pkg.sv =====
package mtep_pkg;

	localparam int BYTE_W  = 8;
	localparam int DELTA_W = 28;
	localparam int TEMPO_W = 24;
	localparam int TPQ_W   = 15;
	localparam int MSG_W   = 24;
	localparam int WAIT_W  = DELTA_W + TEMPO_W;

	// A variable-length field ends at this many bytes whatever the high bit says.
	localparam int DELTA_MAX_BYTES = 4;
	localparam int VLQ_CNT_W       = $clog2(DELTA_MAX_BYTES + 1);

	localparam int DIV_STEPS = TEMPO_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int DEFAULT_TEMPO_INT = 500000;
	localparam int TPQ_RESET_INT     = 60;

	localparam logic [TPQ_W-1:0]   TPQ_RESET     = TPQ_W'(TPQ_RESET_INT);
	localparam logic [TEMPO_W-1:0] DEFAULT_TEMPO = TEMPO_W'(DEFAULT_TEMPO_INT);
	localparam logic [TEMPO_W-1:0] PERIOD_RESET  =
		TEMPO_W'(DEFAULT_TEMPO_INT / TPQ_RESET_INT);

	localparam logic [BYTE_W-1:0] DATA_LIMIT  = 8'h80;
	localparam logic [BYTE_W-1:0] SYS_BASE    = 8'hF0;
	localparam logic [BYTE_W-1:0] STATUS_META = 8'hFF;
	localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
	localparam logic [BYTE_W-1:0] SYSEX_ESC   = 8'hF7;
	localparam logic [BYTE_W-1:0] META_END    = 8'h2F;
	localparam logic [BYTE_W-1:0] META_TEMPO  = 8'h51;
	localparam logic [3:0]        CHAN_PROGRAM  = 4'hC;
	localparam logic [3:0]        CHAN_PRESSURE = 4'hD;

	typedef enum logic [1:0] {
		KIND_CHANNEL = 2'd0,
		KIND_TEMPO   = 2'd1,
		KIND_SKIPPED = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] track_byte;
		logic              restart;
	} track_beat_t;

	typedef struct packed {
		kind_t              event_kind;
		logic [DELTA_W-1:0] delta_ticks;
		logic [WAIT_W-1:0]  wait_us;
		logic [MSG_W-1:0]   short_message;
		logic [TEMPO_W-1:0] us_per_tick;
	} event_beat_t;

	// What the parser finds in the byte offered this cycle.
	typedef struct packed {
		logic               restart;
		logic               emit;
		logic               tempo;
		kind_t              kind;
		logic [DELTA_W-1:0] delta;
		logic [MSG_W-1:0]   msg;
		logic [TEMPO_W-1:0] tempo_value;
	} parse_evt_t;

	typedef struct packed {
		logic take;
		logic mul_en;
		logic div_start;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL    = 5'b00010,
		ST_DSTART = 5'b00100,
		ST_DIV    = 5'b01000,
		ST_LOAD   = 5'b10000
	} ctrl_state_t;

	typedef enum logic [7:0] {
		PH_DELTA     = 8'b00000001,
		PH_STATUS    = 8'b00000010,
		PH_DATA1     = 8'b00000100,
		PH_DATA2     = 8'b00001000,
		PH_META_TYPE = 8'b00010000,
		PH_LENGTH    = 8'b00100000,
		PH_BODY      = 8'b01000000,
		PH_ENDED     = 8'b10000000
	} phase_t;

endpackage

// ===== rtl/midi_track_event_parser_unit.sv =====
// Track byte parser for standard MIDI file event streams.
// Input channel track_valid/track_ready/track_beat carries one track byte per beat,
// with a restart flag that resets the parse and the tempo instead of consuming a byte.
// Output channel event_valid/event_ready/event_beat carries one beat per finished event:
// kind, delta ticks, wait time in microseconds, packed short message and tick period.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes ticks per quarter note;
// cfg_ready is always high and the write takes effect on the next tempo or restart.
// Sequence: a byte that does not finish an event leaves the sequencer idle. A byte that
// finishes an event goes through the multiply, then the load of the output register.
// A tempo event adds the 24-step restoring divider between the two, and a restart
// runs only the divider, to rebuild the default tick period.
// The divider sets the worst case; short of a stalled receiver, a tempo is the slowest byte.
// After reset the tick period is 500000 over 60 and ticks per quarter is 60.
// A stalled receiver holds the result in the output register; the parser keeps taking
// bytes until it has a second result ready, then waits for the register to free up.
`include "midi_track_event_parser_unit_macros.svh"

module midi_track_event_parser_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       track_valid,
	output logic                       track_ready,
	input  mtep_pkg::track_beat_t      track_beat,
	output logic                       event_valid,
	input  logic                       event_ready,
	output mtep_pkg::event_beat_t      event_beat,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mtep_pkg::TPQ_W-1:0] cfg_data
);

	mtep_pkg::parse_evt_t         evt;
	mtep_pkg::ctrl_cmd_t          cmd;
	mtep_pkg::div_stat_t          div_stat;
	logic [mtep_pkg::TEMPO_W-1:0] dividend;
	logic [mtep_pkg::TPQ_W-1:0]   divisor;
	logic [mtep_pkg::TEMPO_W-1:0] quotient;

	// The register can be written at any time the block is idle.
	assign cfg_ready = 1'b1;

	// Byte-level parse state: delta time, running status, meta and sysex lengths.
	mtep_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (cmd.take),
		.beat   (track_beat),
		.evt    (evt)
	);

	// Sequencer for the multiply, the divide and the output register load.
	mtep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (track_valid),
		.in_ready  (track_ready),
		.out_valid (event_valid),
		.out_ready (event_ready),
		.evt       (evt),
		.div_stat  (div_stat),
		.cmd       (cmd)
	);

	// Tempo over ticks per quarter, one quotient bit per cycle.
	mtep_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// Holds the pending event, the tick period, the product and the output register.
	mtep_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.evt       (evt),
		.cfg_we    (cfg_valid),
		.cfg_value (cfg_data),
		.quotient  (quotient),
		.div_done  (div_stat.done),
		.dividend  (dividend),
		.divisor   (divisor),
		.out_beat  (event_beat)
	);

	// New bytes are never taken while the divider is still working.
	`MTEP_ASSERT_IMPL(a_ready_div_idle, track_ready, !div_stat.busy)
	// A restart always rebuilds the tick period through the divider.
	`MTEP_ASSERT_IMPL(a_restart_divides, track_valid && track_ready && track_beat.restart, ##2 div_stat.busy)
	// Loading the output register always presents a result.
	`MTEP_ASSERT_NEXT(a_load_shows, cmd.load_out, event_valid)

endmodule

// ===== rtl/mtep_parser.sv =====
module mtep_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  mtep_pkg::track_beat_t beat,
	output mtep_pkg::parse_evt_t evt
);

	mtep_pkg::phase_t                   phase_q, phase_n;
	logic [mtep_pkg::DELTA_W-1:0]       delta_q, delta_n;
	logic [mtep_pkg::BYTE_W-1:0]        rs_q, rs_n;
	logic [mtep_pkg::BYTE_W-1:0]        fdb_q, fdb_n;
	logic [mtep_pkg::BYTE_W-1:0]        mtype_q, mtype_n;
	logic [mtep_pkg::DELTA_W-1:0]       skip_q, skip_n;
	logic [mtep_pkg::TEMPO_W-1:0]       tempo_q, tempo_n;
	logic [mtep_pkg::VLQ_CNT_W-1:0]     cnt_q, cnt_n;
	logic                               meta_q, meta_n;

	logic [mtep_pkg::BYTE_W-1:0]        b;
	logic [mtep_pkg::VLQ_CNT_W-1:0]     cnt_inc;
	logic                               vlq_done;
	logic [mtep_pkg::DELTA_W-1:0]       delta_shift, skip_shift, skip_dec;
	logic                               one_data;
	logic                               finish;
	logic                               is_tempo_meta;

	assign b           = beat.track_byte;
	assign cnt_inc     = cnt_q + mtep_pkg::VLQ_CNT_W'(1);
	assign vlq_done    = !b[mtep_pkg::BYTE_W-1] ||
		(cnt_inc >= mtep_pkg::VLQ_CNT_W'(mtep_pkg::DELTA_MAX_BYTES));
	assign delta_shift = {delta_q[mtep_pkg::DELTA_W-8:0], b[6:0]};
	assign skip_shift  = {skip_q[mtep_pkg::DELTA_W-8:0], b[6:0]};
	assign skip_dec    = skip_q - mtep_pkg::DELTA_W'(1);
	assign one_data    = (rs_q[7:4] == mtep_pkg::CHAN_PROGRAM) ||
		(rs_q[7:4] == mtep_pkg::CHAN_PRESSURE);
	assign is_tempo_meta = meta_q && (mtype_q == mtep_pkg::META_TEMPO);

	always_comb begin
		phase_n = phase_q;
		delta_n = delta_q;
		rs_n    = rs_q;
		fdb_n   = fdb_q;
		mtype_n = mtype_q;
		skip_n  = skip_q;
		tempo_n = tempo_q;
		cnt_n   = cnt_q;
		meta_n  = meta_q;
		finish  = 1'b0;
		evt     = '0;
		evt.kind = mtep_pkg::KIND_CHANNEL;

		case (phase_q)
			mtep_pkg::PH_DELTA: begin
				delta_n = delta_shift;
				cnt_n   = cnt_inc;
				if (vlq_done) begin
					cnt_n   = '0;
					phase_n = mtep_pkg::PH_STATUS;
				end
			end
			mtep_pkg::PH_STATUS: begin
				if (b < mtep_pkg::DATA_LIMIT) begin
					if (rs_q == '0) begin
						evt.emit = 1'b1;
						evt.kind = mtep_pkg::KIND_SKIPPED;
					end else begin
						fdb_n = b;
						if (one_data) begin
							evt.emit = 1'b1;
							evt.msg  = {8'h00, b, rs_q};
						end else begin
							phase_n = mtep_pkg::PH_DATA2;
						end
					end
				end else if (b < mtep_pkg::SYS_BASE) begin
					rs_n    = b;
					phase_n = mtep_pkg::PH_DATA1;
				end else begin
					rs_n = '0;
					if (b == mtep_pkg::STATUS_META) begin
						meta_n  = 1'b1;
						phase_n = mtep_pkg::PH_META_TYPE;
					end else if (b == mtep_pkg::SYSEX_START || b == mtep_pkg::SYSEX_ESC) begin
						meta_n  = 1'b0;
						mtype_n = '0;
						skip_n  = '0;
						cnt_n   = '0;
						phase_n = mtep_pkg::PH_LENGTH;
					end else begin
						evt.emit = 1'b1;
						evt.kind = mtep_pkg::KIND_SKIPPED;
					end
				end
			end
			mtep_pkg::PH_DATA1: begin
				fdb_n = b;
				if (one_data) begin
					evt.emit = 1'b1;
					evt.msg  = {8'h00, b, rs_q};
				end else begin
					phase_n = mtep_pkg::PH_DATA2;
				end
			end
			mtep_pkg::PH_DATA2: begin
				evt.emit = 1'b1;
				evt.msg  = {b, fdb_q, rs_q};
			end
			mtep_pkg::PH_META_TYPE: begin
				mtype_n = b;
				tempo_n = '0;
				skip_n  = '0;
				cnt_n   = '0;
				phase_n = mtep_pkg::PH_LENGTH;
			end
			mtep_pkg::PH_LENGTH: begin
				skip_n = skip_shift;
				cnt_n  = cnt_inc;
				if (vlq_done) begin
					cnt_n = '0;
					if (skip_shift == '0) begin
						finish = 1'b1;
					end else begin
						phase_n = mtep_pkg::PH_BODY;
					end
				end
			end
			mtep_pkg::PH_BODY: begin
				if (is_tempo_meta) begin
					tempo_n = {tempo_q[mtep_pkg::TEMPO_W-9:0], b};
				end
				skip_n = skip_dec;
				if (skip_dec == '0) begin
					finish = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// A meta or sysex body has ended: classify it.
		if (finish) begin
			evt.emit = 1'b1;
			if (is_tempo_meta) begin
				evt.kind  = mtep_pkg::KIND_TEMPO;
				evt.tempo = 1'b1;
			end else if (meta_q && mtype_q == mtep_pkg::META_END) begin
				evt.kind = mtep_pkg::KIND_END;
			end else begin
				evt.kind = mtep_pkg::KIND_SKIPPED;
			end
		end

		evt.delta       = delta_q;
		evt.tempo_value = tempo_n;

		if (evt.emit) begin
			delta_n = '0;
			cnt_n   = '0;
			phase_n = (evt.kind == mtep_pkg::KIND_END) ? mtep_pkg::PH_ENDED
				: mtep_pkg::PH_DELTA;
		end

		if (beat.restart) begin
			phase_n = mtep_pkg::PH_DELTA;
			delta_n = '0;
			rs_n    = '0;
			fdb_n   = '0;
			mtype_n = '0;
			skip_n  = '0;
			tempo_n = '0;
			cnt_n   = '0;
			meta_n  = 1'b0;
			evt     = '0;
			evt.kind    = mtep_pkg::KIND_CHANNEL;
			evt.restart = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= mtep_pkg::PH_DELTA;
			delta_q <= '0;
			rs_q    <= '0;
			fdb_q   <= '0;
			mtype_q <= '0;
			skip_q  <= '0;
			tempo_q <= '0;
			cnt_q   <= '0;
			meta_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_n;
			delta_q <= delta_n;
			rs_q    <= rs_n;
			fdb_q   <= fdb_n;
			mtype_q <= mtype_n;
			skip_q  <= skip_n;
			tempo_q <= tempo_n;
			cnt_q   <= cnt_n;
			meta_q  <= meta_n;
		end
	end

endmodule

// ===== rtl/mtep_div.sv =====
module mtep_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mtep_pkg::TEMPO_W-1:0] dividend,
	input  logic [mtep_pkg::TPQ_W-1:0]   divisor,
	output logic [mtep_pkg::TEMPO_W-1:0] quotient,
	output mtep_pkg::div_stat_t          stat
);

	// Restoring division, one quotient bit per cycle, most significant first.
	logic [mtep_pkg::TEMPO_W-1:0]   quo_q;
	logic [mtep_pkg::TPQ_W-1:0]     rem_q;
	logic [mtep_pkg::TPQ_W-1:0]     dvs_q;
	logic [mtep_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [mtep_pkg::TPQ_W:0]       trial;
	logic [mtep_pkg::TPQ_W:0]       diff;
	logic                           fits;

	assign trial = {rem_q, quo_q[mtep_pkg::TEMPO_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			quo_q  <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[mtep_pkg::TPQ_W-1:0] : trial[mtep_pkg::TPQ_W-1:0];
			quo_q <= {quo_q[mtep_pkg::TEMPO_W-2:0], fits};
			cnt_q <= cnt_q + mtep_pkg::DIV_CNT_W'(1);
			if (cnt_q == mtep_pkg::DIV_CNT_W'(mtep_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/mtep_ctrl.sv =====
module mtep_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mtep_pkg::parse_evt_t evt,
	input  mtep_pkg::div_stat_t  div_stat,
	output mtep_pkg::ctrl_cmd_t  cmd
);

	mtep_pkg::ctrl_state_t state_q, state_n;
	logic                  emit_pend_q;
	logic                  tempo_pend_q;
	logic                  out_valid_q;
	logic                  slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == mtep_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_n       = state_q;
		cmd           = '0;
		cmd.take      = in_valid && in_ready;
		case (state_q)
			mtep_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (evt.restart) begin
						state_n = mtep_pkg::ST_DSTART;
					end else if (evt.emit) begin
						state_n = mtep_pkg::ST_MUL;
					end
				end
			end
			mtep_pkg::ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_n    = tempo_pend_q ? mtep_pkg::ST_DSTART : mtep_pkg::ST_LOAD;
			end
			mtep_pkg::ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_n       = mtep_pkg::ST_DIV;
			end
			mtep_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_n = emit_pend_q ? mtep_pkg::ST_LOAD : mtep_pkg::ST_IDLE;
				end
			end
			mtep_pkg::ST_LOAD: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_n      = mtep_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = mtep_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mtep_pkg::ST_IDLE;
			emit_pend_q  <= 1'b0;
			tempo_pend_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.take) begin
				emit_pend_q  <= evt.emit;
				tempo_pend_q <= evt.tempo;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/mtep_datapath.sv =====
module mtep_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mtep_pkg::ctrl_cmd_t          cmd,
	input  mtep_pkg::parse_evt_t         evt,
	input  logic                         cfg_we,
	input  logic [mtep_pkg::TPQ_W-1:0]   cfg_value,
	input  logic [mtep_pkg::TEMPO_W-1:0] quotient,
	input  logic                         div_done,
	output logic [mtep_pkg::TEMPO_W-1:0] dividend,
	output logic [mtep_pkg::TPQ_W-1:0]   divisor,
	output mtep_pkg::event_beat_t        out_beat
);

	logic [mtep_pkg::TPQ_W-1:0]   tpq_q;
	logic [mtep_pkg::TEMPO_W-1:0] period_q;
	mtep_pkg::kind_t              kind_q;
	logic [mtep_pkg::DELTA_W-1:0] delta_q;
	logic [mtep_pkg::MSG_W-1:0]   msg_q;
	logic [mtep_pkg::TEMPO_W-1:0] dividend_q;
	logic [mtep_pkg::WAIT_W-1:0]  prod_q;
	mtep_pkg::event_beat_t        out_q;

	// A zero time division is read as one tick per quarter.
	assign divisor  = (tpq_q == '0) ? mtep_pkg::TPQ_W'(1) : tpq_q;
	assign dividend = dividend_q;
	assign out_beat = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpq_q      <= mtep_pkg::TPQ_RESET;
			period_q   <= mtep_pkg::PERIOD_RESET;
			kind_q     <= mtep_pkg::KIND_CHANNEL;
			delta_q    <= '0;
			msg_q      <= '0;
			dividend_q <= '0;
			prod_q     <= '0;
			out_q      <= '0;
		end else begin
			if (cfg_we) begin
				tpq_q <= cfg_value;
			end
			if (cmd.take) begin
				kind_q     <= evt.kind;
				delta_q    <= evt.delta;
				msg_q      <= evt.msg;
				dividend_q <= evt.restart ? mtep_pkg::DEFAULT_TEMPO : evt.tempo_value;
			end
			// Wait time uses the tick period in force before the event.
			if (cmd.mul_en) begin
				prod_q <= mtep_pkg::WAIT_W'(delta_q) * mtep_pkg::WAIT_W'(period_q);
			end
			if (div_done) begin
				period_q <= quotient;
			end
			if (cmd.load_out) begin
				out_q.event_kind    <= kind_q;
				out_q.delta_ticks   <= delta_q;
				out_q.wait_us       <= prod_q;
				out_q.short_message <= msg_q;
				out_q.us_per_tick   <= period_q;
			end
		end
	end

endmodule

// ===== sim/mtep_event_checker.sv =====
`timescale 1ns / 100ps

module mtep_event_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       track_valid,
	input  logic                       track_ready,
	input  mtep_pkg::track_beat_t      track_beat,
	input  logic                       event_valid,
	input  logic                       event_ready,
	input  mtep_pkg::event_beat_t      event_beat,
	input  logic                       cfg_valid,
	input  logic                       cfg_ready,
	input  logic [mtep_pkg::TPQ_W-1:0] cfg_data,
	output int                         mismatches,
	output int                         outstanding,
	output int                         events_checked,
	output int                         tempo_events
);
	import mtep_pkg::*;

	logic [TPQ_W-1:0]   tpq_reg;
	phase_t             stage;
	logic [DELTA_W-1:0] delta_sum;
	logic [DELTA_W-1:0] skip_count;
	logic [BYTE_W-1:0]  run_status;
	logic [BYTE_W-1:0]  first_data;
	logic [BYTE_W-1:0]  meta_code;
	logic [TEMPO_W-1:0] tempo_sum;
	logic [TEMPO_W-1:0] tick_period;
	int                 field_len;
	bit                 body_meta;
	event_beat_t        predicted_events[$];

	// A zero division setting counts as one tick per quarter.
	function automatic logic [TEMPO_W-1:0] period_from(logic [TEMPO_W-1:0] tempo);
		logic [TEMPO_W-1:0] div;
		div = (tpq_reg == '0) ? TEMPO_W'(1) : TEMPO_W'(tpq_reg);
		return tempo / div;
	endfunction

	function automatic bit single_data(logic [BYTE_W-1:0] status);
		return status[7:4] == CHAN_PROGRAM || status[7:4] == CHAN_PRESSURE;
	endfunction

	task automatic begin_track();
		stage = PH_DELTA;
		delta_sum = '0;
		skip_count = '0;
		run_status = '0;
		first_data = '0;
		meta_code = '0;
		tempo_sum = '0;
		field_len = 0;
		body_meta = 1'b0;
		tick_period = period_from(DEFAULT_TEMPO);
	endtask

	task automatic post_event(kind_t kind, logic [MSG_W-1:0] msg,
			logic [TEMPO_W-1:0] period_before);
		event_beat_t ev;
		ev.event_kind = kind;
		ev.delta_ticks = delta_sum;
		ev.wait_us = WAIT_W'(delta_sum) * WAIT_W'(period_before);
		ev.short_message = msg;
		ev.us_per_tick = tick_period;
		predicted_events.insert(predicted_events.size(), ev);
		delta_sum = '0;
		field_len = 0;
		stage = (kind == KIND_END) ? PH_ENDED : PH_DELTA;
	endtask

	task automatic close_body();
		logic [TEMPO_W-1:0] period_prior;
		kind_t              kind;
		period_prior = tick_period;
		kind = KIND_SKIPPED;
		if (body_meta && meta_code == META_TEMPO) begin
			tick_period = period_from(tempo_sum);
			kind = KIND_TEMPO;
		end else if (body_meta && meta_code == META_END) begin
			kind = KIND_END;
		end
		post_event(kind, '0, period_prior);
	endtask

	task automatic parse_track_byte(track_beat_t beat);
		logic [BYTE_W-1:0] b;
		b = beat.track_byte;
		if (beat.restart) begin
			begin_track();
			return;
		end
		case (stage)
		PH_DELTA: begin
			delta_sum = {delta_sum[DELTA_W-8:0], b[6:0]};
			field_len++;
			if (!b[7] || field_len >= DELTA_MAX_BYTES) begin
				field_len = 0;
				stage = PH_STATUS;
			end
		end
		PH_STATUS: begin
			if (b < DATA_LIMIT) begin
				if (run_status == '0) begin
					post_event(KIND_SKIPPED, '0, tick_period);
				end else begin
					first_data = b;
					if (single_data(run_status))
						post_event(KIND_CHANNEL, {8'h00, b, run_status}, tick_period);
					else
						stage = PH_DATA2;
				end
			end else if (b < SYS_BASE) begin
				run_status = b;
				stage = PH_DATA1;
			end else begin
				run_status = '0;
				if (b == STATUS_META) begin
					body_meta = 1'b1;
					stage = PH_META_TYPE;
				end else if (b == SYSEX_START || b == SYSEX_ESC) begin
					body_meta = 1'b0;
					meta_code = '0;
					skip_count = '0;
					field_len = 0;
					stage = PH_LENGTH;
				end else begin
					post_event(KIND_SKIPPED, '0, tick_period);
				end
			end
		end
		PH_DATA1: begin
			first_data = b;
			if (single_data(run_status))
				post_event(KIND_CHANNEL, {8'h00, b, run_status}, tick_period);
			else
				stage = PH_DATA2;
		end
		PH_DATA2: post_event(KIND_CHANNEL, {b, first_data, run_status}, tick_period);
		PH_META_TYPE: begin
			meta_code = b;
			tempo_sum = '0;
			skip_count = '0;
			field_len = 0;
			stage = PH_LENGTH;
		end
		PH_LENGTH: begin
			skip_count = {skip_count[DELTA_W-8:0], b[6:0]};
			field_len++;
			if (!b[7] || field_len >= DELTA_MAX_BYTES) begin
				field_len = 0;
				if (skip_count == '0)
					close_body();
				else
					stage = PH_BODY;
			end
		end
		PH_BODY: begin
			if (body_meta && meta_code == META_TEMPO)
				tempo_sum = {tempo_sum[TEMPO_W-9:0], b};
			skip_count = skip_count - 1'b1;
			if (skip_count == '0)
				close_body();
		end
		default: ;
		endcase
	endtask

	task automatic report_mismatch(string what);
		$display("%0t: event %0d mismatch: %s", $time, events_checked, what);
		mismatches++;
	endtask

	task automatic check_event(event_beat_t got);
		event_beat_t want;
		if (predicted_events.size() == 0) begin
			report_mismatch($sformatf("kind %0d delta %0d arrived with nothing expected",
				got.event_kind, got.delta_ticks));
			return;
		end
		want = predicted_events.pop_front();
		if (got.event_kind !== want.event_kind)
			report_mismatch($sformatf("event_kind %0d, expected %0d",
				got.event_kind, want.event_kind));
		if (got.delta_ticks !== want.delta_ticks)
			report_mismatch($sformatf("delta_ticks %0d, expected %0d",
				got.delta_ticks, want.delta_ticks));
		if (got.wait_us !== want.wait_us)
			report_mismatch($sformatf("wait_us %0d, expected %0d", got.wait_us, want.wait_us));
		if (got.short_message !== want.short_message)
			report_mismatch($sformatf("short_message %h, expected %h",
				got.short_message, want.short_message));
		if (got.us_per_tick !== want.us_per_tick)
			report_mismatch($sformatf("us_per_tick %0d, expected %0d",
				got.us_per_tick, want.us_per_tick));
		if (want.event_kind == KIND_TEMPO)
			tempo_events++;
		events_checked++;
	endtask

	// An event leaving at this edge can never come from a byte taken at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpq_reg = TPQ_RESET;
			begin_track();
			predicted_events.delete();
			mismatches = 0;
			events_checked = 0;
			tempo_events = 0;
		end else begin
			if (event_valid && event_ready)
				check_event(event_beat);
			if (cfg_valid && cfg_ready)
				tpq_reg = cfg_data;
			if (track_valid && track_ready)
				parse_track_byte(track_beat);
		end
		outstanding = predicted_events.size();
	end

endmodule

// ===== sim/tb_midi_track_event_parser_unit.sv =====
`timescale 1ns / 100ps

module tb_midi_track_event_parser_unit;
	import mtep_pkg::*;

	// Random track beats after the opening sequence, spread over the settings below.
	localparam int TARGET_BEATS    = 750;
	// Idle time before a register write and at the end; covers the divider after a
	// restart or a tempo event, which produces nothing on the output for a while.
	localparam int SETTLE_CYCLES   = 64;
	// The one long receiver stall that lets the parser fill up and push back.
	localparam int HOLD_OFF_CYCLES = 300;
	// Cycles without any beat on any channel before the run is declared hung.
	localparam int QUIET_LIMIT     = 5000;

	// Ticks-per-quarter settings, extremes included; zero must act as one.
	localparam int SETTING_COUNT = 7;
	localparam logic [TPQ_W-1:0] TPQ_STEPS [SETTING_COUNT] =
		'{15'd1, 15'd32767, 15'd0, 15'd480, 15'd96, 15'd7, 15'd60};

	// Opening sequence, sent between two restarts at the reset setting:
	// a data byte with no running status, a four-byte delta whose last byte still
	// has its high bit set followed by a note with status bytes in its data slots,
	// a tempo with a four-byte body (only the low 24 bits count), a lone system
	// byte, a sysex of zero length, end of track, and one byte after the end.
	localparam int OPENING_LEN = 27;
	localparam logic [BYTE_W-1:0] OPENING [OPENING_LEN] = '{
		8'h00, 8'h45,
		8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h92, 8'h80, 8'hFF,
		8'h00, 8'hFF, 8'h51, 8'h04, 8'hAB, 8'h07, 8'hA1, 8'h20,
		8'h00, 8'hF4,
		8'h00, 8'hF0, 8'h00,
		8'h00, 8'hFF, 8'h2F, 8'h00,
		8'h00
	};

	logic              clk;
	logic              arst_n;
	logic              track_valid;
	logic              track_ready;
	track_beat_t       track_beat;
	logic              event_valid;
	logic              event_ready;
	event_beat_t       event_beat;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [TPQ_W-1:0]  cfg_data;

	int                mismatches;
	int                outstanding;
	int                events_checked;
	int                tempo_events;

	int                beats_taken;
	int                burst_left;
	int                quiet_cycles;
	int                settings_used;
	bit                hold_request;
	logic [BYTE_W-1:0] status_in_use;
	track_beat_t       beat_plan[$];

	midi_track_event_parser_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.track_valid (track_valid),
		.track_ready (track_ready),
		.track_beat  (track_beat),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.event_beat  (event_beat),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	// The checker watches all three channels, keeps its own copy of the parser
	// state and compares every event beat with its prediction.
	mtep_event_checker events_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.track_valid    (track_valid),
		.track_ready    (track_ready),
		.track_beat     (track_beat),
		.event_valid    (event_valid),
		.event_ready    (event_ready),
		.event_beat     (event_beat),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding),
		.events_checked (events_checked),
		.tempo_events   (tempo_events)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: any beat on any channel proves progress. The longest honest
	// silence is the receiver hold-off plus a tempo division, far below the limit.
	always @(posedge clk) begin
		if (!arst_n || (track_valid && track_ready) || (event_valid && event_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no beat on any channel for %0d cycles.", QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// Receiver. It changes its stall pattern at random intervals: always ready,
	// a coin toss, mostly stalled, or a fixed rhythm. When asked, it holds off for a
	// long stretch that it counts itself, so the sender keeps pushing into a full block.
	initial begin
		int mode;
		int stretch;
		int hold_left;
		int tick;
		mode = 0;
		stretch = 0;
		hold_left = 0;
		tick = 0;
		event_ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				event_ready = 1'b0;
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 3);
					stretch = $urandom_range(16, 160);
				end
				stretch--;
				case (mode)
				0: event_ready = 1'b1;
				1: event_ready = 1'($urandom_range(0, 1));
				2: event_ready = ($urandom_range(0, 7) == 0);
				default: event_ready = (tick % 5 != 0);
				endcase
			end
		end
	end

	task automatic plan_byte(logic [BYTE_W-1:0] b);
		beat_plan.insert(beat_plan.size(), track_beat_t'{track_byte: b, restart: 1'b0});
	endtask

	// A restart beat carries a random byte, which the parser must throw away.
	task automatic plan_restart();
		beat_plan.insert(beat_plan.size(),
			track_beat_t'{track_byte: 8'($urandom), restart: 1'b1});
		status_in_use = '0;
	endtask

	// Variable-length quantity, most significant group first. With pad set the
	// value is stretched to the full field width with empty leading groups.
	task automatic plan_vlq(logic [DELTA_W-1:0] value, bit pad);
		logic [BYTE_W-1:0] groups[$];
		int                n;
		groups.push_front({1'b0, value[6:0]});
		n = 1;
		while ((value >> (7 * n)) != 0 && n < DELTA_MAX_BYTES) begin
			groups.push_front({1'b1, 7'(value >> (7 * n))});
			n++;
		end
		while (pad && n < DELTA_MAX_BYTES) begin
			groups.push_front(8'h80);
			n++;
		end
		foreach (groups[i])
			plan_byte(groups[i]);
	endtask

	// Mostly short deltas; now and then the full 28-bit range, and sometimes a
	// field whose every byte has the high bit set, which ends at the size limit.
	task automatic plan_delta();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			plan_vlq(DELTA_W'($urandom_range(0, 127)), pick == 0);
		else if (pick < 7)
			plan_vlq(DELTA_W'($urandom_range(0, 16383)), 1'b0);
		else if (pick < 9)
			plan_vlq(DELTA_W'($urandom), 1'b0);
		else
			repeat (DELTA_MAX_BYTES) plan_byte(8'($urandom) | 8'h80);
	endtask

	// Data bytes for the status in force; now and then a status byte sits in a
	// data slot, which the parser must take as plain data.
	task automatic plan_data(logic [BYTE_W-1:0] status);
		int count;
		count = (status[7:4] == CHAN_PROGRAM || status[7:4] == CHAN_PRESSURE
			|| status == '0) ? 1 : 2;
		repeat (count)
			plan_byte(($urandom_range(0, 19) == 0) ? 8'($urandom_range(128, 255))
				: 8'($urandom_range(0, 127)));
	endtask

	task automatic plan_body(int len);
		repeat (len) plan_byte(8'($urandom));
	endtask

	// One well-formed event most of the time; the rest are restarts and noise.
	task automatic plan_event();
		int                 pick;
		int                 len;
		logic [BYTE_W-1:0]  code;
		logic [TEMPO_W-1:0] tempo;
		plan_delta();
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			status_in_use = 8'($urandom_range(8'h80, 8'hEF));
			plan_byte(status_in_use);
			plan_data(status_in_use);
		end else if (pick < 55) begin
			// Running status; with none in force this is a lone data byte.
			plan_data(status_in_use);
		end else if (pick < 65) begin
			status_in_use = '0;
			plan_byte(STATUS_META);
			plan_byte(META_TEMPO);
			len = ($urandom_range(0, 4) != 0) ? 3 : $urandom_range(0, 6);
			plan_vlq(DELTA_W'(len), $urandom_range(0, 7) == 0);
			case ($urandom_range(0, 7))
			0: tempo = '0;
			1: tempo = '1;
			2, 3: tempo = TEMPO_W'($urandom);
			default: tempo = TEMPO_W'($urandom_range(200000, 1500000));
			endcase
			if (len == 3) begin
				plan_byte(tempo[23:16]);
				plan_byte(tempo[15:8]);
				plan_byte(tempo[7:0]);
			end else begin
				plan_body(len);
			end
		end else if (pick < 73) begin
			status_in_use = '0;
			code = 8'($urandom);
			if (code == META_TEMPO || code == META_END)
				code = 8'h01;
			plan_byte(STATUS_META);
			plan_byte(code);
			len = ($urandom_range(0, 15) == 0) ? 130 : $urandom_range(0, 5);
			plan_vlq(DELTA_W'(len), 1'b0);
			plan_body(len);
		end else if (pick < 80) begin
			status_in_use = '0;
			plan_byte($urandom_range(0, 1) ? SYSEX_START : SYSEX_ESC);
			len = $urandom_range(0, 6);
			plan_vlq(DELTA_W'(len), $urandom_range(0, 5) == 0);
			plan_body(len);
		end else if (pick < 86) begin
			status_in_use = '0;
			code = 8'($urandom_range(8'hF1, 8'hFE));
			if (code == SYSEX_ESC)
				code = 8'hF6;
			plan_byte(code);
		end else if (pick < 89) begin
			// End of track; whatever follows is ignored until the restart.
			plan_byte(STATUS_META);
			plan_byte(META_END);
			len = ($urandom_range(0, 9) == 0) ? 1 : 0;
			plan_vlq(DELTA_W'(len), 1'b0);
			plan_body(len);
			plan_body($urandom_range(0, 2));
			plan_restart();
		end else if (pick < 93) begin
			plan_restart();
		end else begin
			plan_body($urandom_range(1, 3));
		end
	endtask

	// Sender: bursts of random length, random gaps between them, and now and then
	// a long burst with no gap at all. Valid stays high across back-to-back beats.
	task automatic send_beat(track_beat_t beat);
		if (burst_left == 0) begin
			@(negedge clk);
			track_valid = 1'b0;
			track_beat = {8'($urandom), 1'($urandom)};
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 20);
		end
		burst_left--;
		@(negedge clk);
		track_valid = 1'b1;
		track_beat = beat;
		do @(posedge clk); while (!track_ready);
		beats_taken++;
	endtask

	task automatic send_plan();
		while (beat_plan.size() != 0)
			send_beat(beat_plan.pop_front());
	endtask

	// The register is written only with the parser idle: every predicted event
	// delivered and enough time for a pending division to finish.
	task automatic write_ticks_per_quarter(logic [TPQ_W-1:0] value);
		@(negedge clk);
		track_valid = 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		settings_used++;
	endtask

	initial begin
		int per_phase;
		int phase_end;
		track_valid = 1'b0;
		track_beat = '0;
		cfg_valid = 1'b0;
		cfg_data = TPQ_RESET;
		hold_request = 1'b0;
		status_in_use = '0;
		beat_plan.delete();
		burst_left = 0;
		beats_taken = 0;
		settings_used = 1;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Opening sequence at the reset setting of 60 ticks per quarter.
		plan_restart();
		foreach (OPENING[i])
			plan_byte(OPENING[i]);
		plan_restart();
		send_plan();

		// Random part. Every other setting starts with a restart so the new division
		// takes effect at once; the others keep the old tick period until a tempo
		// event, since a register write alone does not touch it.
		per_phase = TARGET_BEATS / SETTING_COUNT;
		phase_end = beats_taken;
		for (int p = 0; p < SETTING_COUNT; p++) begin
			write_ticks_per_quarter((p == 4) ? TPQ_W'($urandom_range(1, 32767))
				: TPQ_STEPS[p]);
			if (p % 2 == 0)
				plan_restart();
			if (p == 0)
				hold_request = 1'b1;
			phase_end += per_phase;
			while (beats_taken < phase_end) begin
				plan_event();
				send_plan();
			end
		end

		@(negedge clk);
		track_valid = 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d track beats under %0d ticks-per-quarter settings, with one long",
			beats_taken, settings_used);
		$display("receiver hold-off; %0d events compared, %0d of them tempo changes.",
			events_checked, tempo_events);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
